// ----- rtl/core/bsd_pkg.sv -----
// ----------------------------------------------------------------------------
// bsd_pkg: shared types and constants of the bitmap shape drawer
// Command and result item layouts, command codes, register indexes and the
// row span helper used by the draw and read-out logic.
// ----------------------------------------------------------------------------
package bsd_pkg;

   // Fixed field widths
   localparam int ROW_W     = 64;  // bits of one result row
   localparam int ROW_IDX_W = 6;   // row index field
   localparam int DIM_W     = 7;   // canvas width / height registers
   localparam int CSR_IDX_W = 1;   // register index

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 1'd1;

   // Command codes
   localparam logic [1:0] OP_SQUARE   = 2'd0;
   localparam logic [1:0] OP_TRIANGLE = 2'd1;
   localparam logic [1:0] OP_LINE     = 2'd2;
   localparam logic [1:0] OP_NONE     = 2'd3;

   // Triangle opening, "up" is toward row 0
   localparam logic [1:0] DIR_RU = 2'd0;
   localparam logic [1:0] DIR_RD = 2'd1;
   localparam logic [1:0] DIR_LU = 2'd2;
   localparam logic [1:0] DIR_LD = 2'd3;

   // Result status codes
   localparam logic STATUS_ROW = 1'b0;
   localparam logic STATUS_OOR = 1'b1;

   typedef struct packed {
      logic [1:0]        op;
      logic [6:0]        size;
      logic signed [7:0] x;
      logic signed [7:0] y;
      logic signed [7:0] end_x;
      logic signed [7:0] end_y;
      logic [1:0]        direction;
   } req_item_type;

   typedef struct packed {
      logic                 status;
      logic [ROW_IDX_W-1:0] row_index;
      logic [ROW_W-1:0]     row_bits;
      logic                 last;
   } rsp_item_type;

   // len ones starting at column lo; len of 64 or more fills from lo to the end of the row
   function automatic logic [ROW_W-1:0] bsd_span(input logic [ROW_IDX_W-1:0] lo,
                                                  input logic [DIM_W-1:0] len);
      logic [ROW_W-1:0] ones;
      ones = '1;
      if (len == '0)
         return '0;
      if (len >= DIM_W'(ROW_W))
         return ones << lo;
      return (ones >> (DIM_W'(ROW_W) - len)) << lo;
   endfunction

endpackage

// ----- rtl/core/bsd_if.sv -----
// ----------------------------------------------------------------------------
// bsd_if: command and result channels of the bitmap shape drawer
// Valid/ready channels; an item moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface bsd_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        op;
   logic [6:0]        size;
   logic signed [7:0] x;
   logic signed [7:0] y;
   logic signed [7:0] end_x;
   logic signed [7:0] end_y;
   logic [1:0]        direction;

   modport source (output valid, op, size, x, y, end_x, end_y, direction, input ready);
   modport sink   (input valid, op, size, x, y, end_x, end_y, direction, output ready);
endinterface

interface bsd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           status;
   logic [bsd_pkg::ROW_IDX_W-1:0]  row_index;
   logic [bsd_pkg::ROW_W-1:0]      row_bits;
   logic                           last;

   modport source (output valid, status, row_index, row_bits, last, input ready);
   modport sink   (input valid, status, row_index, row_bits, last, output ready);
endinterface

// ----- rtl/core/bsd_ram.sv -----
// ----------------------------------------------------------------------------
// bsd_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module bsd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en)
         mem_ff[wr_addr] <= wr_data;
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en)
         rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/bsd_engine.sv -----
// ----------------------------------------------------------------------------
// bsd_engine: command sequencer of the bitmap shape drawer
// Checks bounds, walks the rows of a shape with a read-modify-write per row
// on the canvas RAM, then streams every canvas row in use out through a
// 2-entry result queue; a command out of bounds gives one out-of-range item.
// ----------------------------------------------------------------------------
module bsd_engine #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64,
   localparam int ROW_AW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   bsd_req_if.sink                   req_ch,
   bsd_rsp_if.source                 rsp_ch,
   input  logic [bsd_pkg::DIM_W-1:0] width_eff,
   input  logic [bsd_pkg::DIM_W-1:0] height_eff,
   output logic                      ram_re,
   output logic [ROW_AW-1:0]         ram_raddr,
   input  logic [MAX_WIDTH-1:0]      ram_rdata,
   output logic                      ram_we,
   output logic [ROW_AW-1:0]         ram_waddr,
   output logic [MAX_WIDTH-1:0]      ram_wdata
);
   import bsd_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CHECK  = 5'b00010,
      ST_DRAW   = 5'b00100,
      ST_READ   = 5'b01000,
      ST_REPORT = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   req_item_type          cmd_ff, cmd_in;

   // shape walk
   logic [ROW_IDX_W-1:0]  row_ff, row_in;
   logic                  up_ff, up_in;
   logic [DIM_W-1:0]      n_ff, n_in;
   logic signed [8:0]     lo_ff, lo_in;
   logic [DIM_W-1:0]      len_ff, len_in;
   logic signed [1:0]     lo_step_ff, lo_step_in;
   logic                  len_dec_ff, len_dec_in;
   logic                  diag_ff, diag_in;

   // read-modify-write stage
   logic                  rmw_pend_ff, rmw_pend_in;
   logic                  rmw_we_ff, rmw_we_in;
   logic [ROW_IDX_W-1:0]  rmw_row_ff, rmw_row_in;
   logic [MAX_WIDTH-1:0]  rmw_mask_ff, rmw_mask_in;

   // read-out stage
   logic [ROW_IDX_W-1:0]  rd_row_ff, rd_row_in;
   logic                  out_pend_ff, out_pend_in;
   logic [ROW_IDX_W-1:0]  out_row_ff, out_row_in;
   logic                  out_last_ff, out_last_in;

   // row valid bits: a row never written reads as unmarked
   logic [MAX_HEIGHT-1:0] valid_ff, valid_in;
   logic                  rd_vld_ff, rd_vld_in;

   // result queue
   rsp_item_type          q_ff [2];
   rsp_item_type          q_in [2];
   logic                  wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]            cnt_ff, cnt_in;

   // bounds check and walk setup
   logic signed [9:0]     xs, ys, exs, eys, szs, ws, hs;
   logic signed [9:0]     dy, ady, dx, adx, c0, r0;
   logic                  bad, up0, left0;
   logic [ROW_IDX_W-1:0]  row0;
   logic [DIM_W-1:0]      n0, len0;
   logic signed [8:0]     lo0;
   logic signed [1:0]     lo_step0;
   logic                  len_dec0, diag0;

   logic                  acc, pop, space, draw_go, read_go, last_read;
   logic signed [8:0]     lo_use;
   logic                  step_we;
   logic [ROW_W-1:0]      step_mask, wmask;
   logic [MAX_WIDTH-1:0]  old_row;
   logic                  push;
   rsp_item_type          push_item;

   // ---------------- bounds check and walk setup ----------------
   always_comb begin
      xs  = 10'(cmd_ff.x);
      ys  = 10'(cmd_ff.y);
      exs = 10'(cmd_ff.end_x);
      eys = 10'(cmd_ff.end_y);
      szs = 10'(cmd_ff.size);
      ws  = 10'(width_eff);
      hs  = 10'(height_eff);
      dy  = eys - ys;
      ady = (dy < 10'sd0) ? -dy : dy;
      dx  = exs - xs;
      adx = (dx < 10'sd0) ? -dx : dx;
      c0  = (xs < exs) ? xs : exs;
      r0  = (ys < eys) ? ys : eys;
      up0   = (cmd_ff.direction == DIR_RU) || (cmd_ff.direction == DIR_LU);
      left0 = (cmd_ff.direction == DIR_LU) || (cmd_ff.direction == DIR_LD);

      bad      = 1'b0;
      row0     = cmd_ff.y[ROW_IDX_W-1:0];
      n0       = cmd_ff.size;
      len0     = cmd_ff.size;
      lo0      = 9'(cmd_ff.x);
      lo_step0 = 2'sd0;
      len_dec0 = 1'b0;
      diag0    = 1'b0;
      case (cmd_ff.op)
         OP_SQUARE: begin
            bad = (xs < 10'sd0) || (ys < 10'sd0) || (xs + szs > ws) || (ys + szs > hs);
         end
         OP_TRIANGLE: begin
            case (cmd_ff.direction)
               DIR_RU: bad = (ys >= hs) || (xs + szs > ws) ||
                             (ys - szs < -10'sd1) || (xs < 10'sd0);
               DIR_RD: bad = (ys + szs > hs) || (xs + szs > ws) ||
                             (xs < 10'sd0) || (ys < 10'sd0);
               DIR_LU: bad = (ys >= hs) || (xs >= ws) ||
                             (xs - szs < -10'sd1) || (ys - szs < -10'sd1);
               default: bad = (ys + szs > hs) || (xs >= ws) ||
                              (xs - szs < -10'sd1) || (ys < 10'sd0);
            endcase
            len_dec0 = 1'b1;
            if (left0) begin
               lo0      = 9'(xs - szs + 10'sd1);
               lo_step0 = 2'sd1;
            end
         end
         OP_LINE: begin
            bad = (xs < 10'sd0) || (ys < 10'sd0) || (exs < 10'sd0) || (eys < 10'sd0) ||
                  (xs >= ws) || (ys >= hs) || (exs >= ws) || (eys >= hs);
            n0 = DIM_W'(ady + 10'sd1);
            if ((xs == exs) || (ys == eys)) begin
               row0 = r0[ROW_IDX_W-1:0];
               lo0  = 9'(c0);
               len0 = DIM_W'(adx + 10'sd1);
            end else begin
               len0     = DIM_W'(1);
               diag0    = 1'b1;
               lo_step0 = (exs > xs) ? 2'sd1 : -2'sd1;
            end
         end
         default: bad = 1'b0;
      endcase
   end

   // ---------------- per-row step ----------------
   always_comb begin
      // the end pixel of a diagonal takes the end column
      lo_use    = (diag_ff && (n_ff == DIM_W'(1))) ? 9'(cmd_ff.end_x) : lo_ff;
      step_we   = (len_ff != '0) && !lo_use[8] && (lo_use < 9'(width_eff));
      step_mask = bsd_span(lo_use[ROW_IDX_W-1:0], len_ff);
      wmask     = bsd_span('0, width_eff);
   end

   // handshakes and queue credit
   assign acc       = req_ch.valid && req_ch.ready;
   assign pop       = rsp_ch.valid && rsp_ch.ready;
   assign space     = (3'(cnt_ff) + 3'(out_pend_ff)) < (3'd2 + 3'(pop));
   assign draw_go   = (state_ff == ST_DRAW) && (n_ff != '0);
   assign read_go   = (state_ff == ST_READ) && space;
   assign last_read = (DIM_W'(rd_row_ff) == height_eff - DIM_W'(1));

   // ---------------- RAM ports ----------------
   assign ram_re    = draw_go || read_go;
   assign ram_raddr = draw_go ? row_ff[ROW_AW-1:0] : rd_row_ff[ROW_AW-1:0];
   assign old_row   = rd_vld_ff ? ram_rdata : '0;
   assign ram_we    = rmw_pend_ff && rmw_we_ff;
   assign ram_waddr = rmw_row_ff[ROW_AW-1:0];
   assign ram_wdata = old_row | rmw_mask_ff;

   // ---------------- result queue push ----------------
   always_comb begin
      push = out_pend_ff || ((state_ff == ST_REPORT) && space);
      if (out_pend_ff) begin
         push_item.status    = STATUS_ROW;
         push_item.row_index = out_row_ff;
         push_item.row_bits  = ROW_W'(old_row) & wmask;
         push_item.last      = out_last_ff;
      end else begin
         push_item.status    = STATUS_OOR;
         push_item.row_index = '0;
         push_item.row_bits  = '0;
         push_item.last      = 1'b1;
      end
   end

   // ---------------- next state ----------------
   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      row_in      = row_ff;
      up_in       = up_ff;
      n_in        = n_ff;
      lo_in       = lo_ff;
      len_in      = len_ff;
      lo_step_in  = lo_step_ff;
      len_dec_in  = len_dec_ff;
      diag_in     = diag_ff;
      rd_row_in   = rd_row_ff;

      case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               cmd_in.op        = req_ch.op;
               cmd_in.size      = req_ch.size;
               cmd_in.x         = req_ch.x;
               cmd_in.y         = req_ch.y;
               cmd_in.end_x     = req_ch.end_x;
               cmd_in.end_y     = req_ch.end_y;
               cmd_in.direction = req_ch.direction;
               state_in         = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (cmd_ff.op == OP_NONE) begin
               state_in = ST_IDLE;
            end else if (bad) begin
               state_in = ST_REPORT;
            end else begin
               state_in   = ST_DRAW;
               row_in     = row0;
               up_in      = (cmd_ff.op == OP_TRIANGLE) ? up0 :
                            (diag0 && (eys < ys));
               n_in       = n0;
               lo_in      = lo0;
               len_in     = len0;
               lo_step_in = lo_step0;
               len_dec_in = len_dec0;
               diag_in    = diag0;
            end
         end
         ST_DRAW: begin
            if (draw_go) begin
               row_in = up_ff ? row_ff - 1'b1 : row_ff + 1'b1;
               n_in   = n_ff - 1'b1;
               lo_in  = lo_ff + 9'(lo_step_ff);
               len_in = len_ff - DIM_W'(len_dec_ff);
            end else begin
               // last write lands this cycle, before the first read-out read
               state_in  = ST_READ;
               rd_row_in = '0;
            end
         end
         ST_READ: begin
            if (read_go) begin
               rd_row_in = rd_row_ff + 1'b1;
               if (last_read)
                  state_in = ST_IDLE;
            end
         end
         ST_REPORT: begin
            if (space)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // pipeline stages, valid bits and queue
   always_comb begin
      rmw_pend_in = draw_go;
      rmw_we_in   = step_we;
      rmw_row_in  = row_ff;
      rmw_mask_in = step_mask[MAX_WIDTH-1:0];
      out_pend_in = read_go;
      out_row_in  = rd_row_ff;
      out_last_in = last_read;
      rd_vld_in   = valid_ff[ram_raddr];

      valid_in = valid_ff;
      if (ram_we)
         valid_in[ram_waddr] = 1'b1;

      q_in = q_ff;
      if (push)
         q_in[wp_ff] = push_item;
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rmw_pend_ff <= 1'b0;
         out_pend_ff <= 1'b0;
         valid_ff    <= '0;
         wp_ff       <= 1'b0;
         rp_ff       <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         rmw_pend_ff <= rmw_pend_in;
         out_pend_ff <= out_pend_in;
         valid_ff    <= valid_in;
         wp_ff       <= wp_in;
         rp_ff       <= rp_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      row_ff      <= row_in;
      up_ff       <= up_in;
      n_ff        <= n_in;
      lo_ff       <= lo_in;
      len_ff      <= len_in;
      lo_step_ff  <= lo_step_in;
      len_dec_ff  <= len_dec_in;
      diag_ff     <= diag_in;
      rd_row_ff   <= rd_row_in;
      rmw_we_ff   <= rmw_we_in;
      rmw_row_ff  <= rmw_row_in;
      rmw_mask_ff <= rmw_mask_in;
      out_row_ff  <= out_row_in;
      out_last_ff <= out_last_in;
      rd_vld_ff   <= rd_vld_in;
      q_ff        <= q_in;
   end

   // ---------------- outputs ----------------
   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign rsp_ch.valid     = (cnt_ff != '0);
   assign rsp_ch.status    = q_ff[rp_ff].status;
   assign rsp_ch.row_index = q_ff[rp_ff].row_index;
   assign rsp_ch.row_bits  = q_ff[rp_ff].row_bits;
   assign rsp_ch.last      = q_ff[rp_ff].last;

   // ---------------- assertions ----------------
   // queue never overflows: a push always finds a free entry
   assert property (@(posedge clock) disable iff (reset)
      push |-> ((cnt_ff != 2'd2) || pop))
      else $error("bsd_engine: result queue overflow");

   // queue occupancy stays within two entries
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("bsd_engine: result queue count out of range");

   // a row is never read in the same cycle it is written back
   assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
      else $error("bsd_engine: read of a row under write-back");

   // draw and read-out data never share the RAM read cycle
   assert property (@(posedge clock) disable iff (reset)
      !(rmw_pend_ff && out_pend_ff))
      else $error("bsd_engine: draw and read-out reads overlap");

   // an accepted command is always checked in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      acc |=> (state_ff == ST_CHECK))
      else $error("bsd_engine: accepted item not checked");

endmodule

// ----- rtl/core/bitmap_shape_drawer.sv -----
// ----------------------------------------------------------------------------
// bitmap_shape_drawer: one-bit-per-pixel canvas with shape drawing commands
// Top level: canvas size registers, canvas RAM and the command sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one drawing command per item (square, triangle or line);
//   rsp_ch returns either one out-of-range item or every canvas row in use,
//   row 0 first, with last set on the final row. Op code 3 gives no items.
//   csr_* writes the canvas width (index 0) and height (index 1); write them
//   only while no command is in flight.
// Command sequence:
//   A command is first checked, then walked one shape row at a time with a
//   read-modify-write (size rows, or the row span of a line), then read out
//   one canvas row at a time. The walk and the read-out both use the single
//   read port of the canvas RAM once per cycle, the read-out only while the
//   result queue has room.
// Reset: the canvas reads as all unmarked (per-row valid bits are cleared),
//   width and height return to 64; no clearing pass is needed.
// Stall: the result side has a 2-entry queue; when rsp_ch.ready is low the
//   read-out waits on queue credit and no item is lost. A new command is taken
//   as soon as the last result of the previous one is queued.
// ----------------------------------------------------------------------------
module bitmap_shape_drawer #(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   bsd_req_if.sink                       req_ch,
   bsd_rsp_if.source                     rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [bsd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bsd_pkg::DIM_W-1:0]     csr_wr_data
);
   import bsd_pkg::*;

   localparam int ROW_AW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   logic [DIM_W-1:0]     width_ff, width_in;
   logic [DIM_W-1:0]     height_ff, height_in;
   logic [DIM_W-1:0]     width_eff, height_eff;

   logic                 ram_re, ram_we;
   logic [ROW_AW-1:0]    ram_raddr, ram_waddr;
   logic [MAX_WIDTH-1:0] ram_rdata, ram_wdata;

   // canvas size registers
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_WIDTH:  width_in  = csr_wr_data;
            CSR_HEIGHT: height_in = csr_wr_data;
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(64);
         height_ff <= DIM_W'(64);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // zero acts as one, large values saturate to the canvas maximum
   always_comb begin
      if (width_ff == '0)
         width_eff = DIM_W'(1);
      else if (width_ff > DIM_W'(MAX_WIDTH))
         width_eff = DIM_W'(MAX_WIDTH);
      else
         width_eff = width_ff;

      if (height_ff == '0)
         height_eff = DIM_W'(1);
      else if (height_ff > DIM_W'(MAX_HEIGHT))
         height_eff = DIM_W'(MAX_HEIGHT);
      else
         height_eff = height_ff;
   end

   // canvas storage, one row per entry
   bsd_ram #(
      .WIDTH (MAX_WIDTH),
      .DEPTH (MAX_HEIGHT)
   ) u_canvas (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   bsd_engine #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .width_eff  (width_eff),
      .height_eff (height_eff),
      .ram_re     (ram_re),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata)
   );

endmodule
